### hdl/slab_object_allocator_assert.svh
// Assertion macros for the slab object allocator.
// Used by the top level only; expands to nothing when SYNTHESIS is defined.
`ifndef SLAB_OBJECT_ALLOCATOR_ASSERT_SVH
`define SLAB_OBJECT_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
// Condition must hold at every edge outside reset
`define SA_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("slab allocator assertion failed");
// Antecedent implies consequent in the same cycle
`define SA_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slab allocator assertion failed");
// Antecedent implies consequent in the next cycle
`define SA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slab allocator assertion failed");
`else
`define SA_ASSERT_ALWAYS(label, clk, rst, cond)
`define SA_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define SA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### hdl/slab_alloc_pkg.sv
// Shared constants for the slab object allocator: field widths, codes and
// parameter defaults. No dependencies.
package slab_alloc_pkg;

   localparam int ADDR_W   = 16;
   localparam int SIZE_W   = 13;
   localparam int STATUS_W = 2;

   localparam int MAX_SLABS_DEF   = 16;
   localparam int SLAB_BYTES_DEF  = 4096;
   localparam int MAX_OBJECTS_DEF = 64;

   localparam logic [SIZE_W-1:0] OBJ_SIZE_RESET = 13'd128;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OOM      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NO_SLAB  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_ALL_FREE = 2'd3;

endpackage

### hdl/slab_alloc_mac.sv
// Shared multiply-compare unit: offset = factor * size, and whether one more
// object of that size still fits in the page. Depends on slab_alloc_pkg.
module slab_alloc_mac import slab_alloc_pkg::*; #(
   parameter int FW         = 7,
   parameter int OW         = 12,
   parameter int SLAB_BYTES = SLAB_BYTES_DEF
) (
   input  logic              clock,
   input  logic [FW-1:0]     factor,
   input  logic [SIZE_W-1:0] obj_size,
   output logic [OW-1:0]     offset,
   output logic              fits
);

   localparam int PW   = FW + SIZE_W;
   localparam int CMPW = (PW + 1 > 18) ? PW + 1 : 18;

   logic [SIZE_W-1:0] size_eff;
   logic [PW-1:0]     prod;
   logic [CMPW-1:0]   prod_ext;
   logic [CMPW-1:0]   next_end;
   logic [OW-1:0]     offset_ff;
   logic              fits_ff;

   // a zero size behaves as one byte
   assign size_eff = (obj_size == '0) ? SIZE_W'(1) : obj_size;
   assign prod     = PW'(factor) * PW'(size_eff);
   assign prod_ext = CMPW'(prod);
   assign next_end = prod_ext + CMPW'(size_eff);

   always_ff @(posedge clock) begin
      offset_ff <= prod_ext[OW-1:0];
      fits_ff   <= (next_end <= CMPW'(SLAB_BYTES));
   end

   assign offset = offset_ff;
   assign fits   = fits_ff;

endmodule

### hdl/slab_alloc_store.sv
// Free-offset stack storage: one write port, one registered read port.
// Entry {slab, position} holds one free offset. Depends on slab_alloc_pkg.
module slab_alloc_store import slab_alloc_pkg::*; #(
   parameter int AW = 10,
   parameter int DW = 12
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [2**AW];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/slab_object_allocator.sv
// Channel   Dir  Payload                                    Handshake
// req_      in   tdata: free_address; tuser: req_type       tvalid/tready
// rsp_      out  tdata: object_address; tuser: status,      tvalid/tready
//                slab_created
// csr_      in   object size                                wr_en strobe
//
// States from transfer in to result loaded: a pop DECIDE, POP, RESP; a free DECIDE,
// FCMP, RESP (DECIDE, RESP outside every slab); an allocate with no free object and
// no page left DECIDE, RESP; a new slab DECIDE, a multiply-compare pass (FMUL, FWR)
// per object, RESP. Reset clears the sequencer, free counts, slab count and
// object size; the offset store is not cleared. One request is in flight; a new one
// is taken while the previous result waits in the output register.
module slab_object_allocator import slab_alloc_pkg::*; #(
   parameter int MAX_SLABS   = MAX_SLABS_DEF,
   parameter int SLAB_BYTES  = SLAB_BYTES_DEF,   // power of two
   parameter int MAX_OBJECTS = MAX_OBJECTS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [ADDR_W-1:0]   req_tdata,   // [15:0] free_address
   input  logic [0:0]          req_tuser,   // [0] req_type
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [ADDR_W-1:0]   rsp_tdata,   // [15:0] object_address
   output logic [2:0]          rsp_tuser,   // [1:0] status, [2] slab_created
   input  logic                csr_wr_en,
   input  logic [SIZE_W-1:0]   csr_wr_data
);

`include "slab_object_allocator_assert.svh"

   localparam int SW = (MAX_SLABS > 1) ? $clog2(MAX_SLABS) : 1;
   localparam int UW = $clog2(MAX_SLABS + 1);
   localparam int KW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
   localparam int CW = $clog2(MAX_OBJECTS + 1);
   localparam int OW = $clog2(SLAB_BYTES);
   localparam int AW = SW + KW;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECIDE = 3'd1;
   localparam logic [2:0] S_POP    = 3'd2;
   localparam logic [2:0] S_FMUL   = 3'd3;
   localparam logic [2:0] S_FWR    = 3'd4;
   localparam logic [2:0] S_FCMP   = 3'd5;
   localparam logic [2:0] S_RESP   = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic                type_ff, type_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [SW-1:0]       slab_ff, slab_in;
   logic [CW-1:0]       k_ff, k_in;
   logic [OW-1:0]       last_off_ff, last_off_in;
   logic [UW-1:0]       inuse_ff, inuse_in;
   logic [SIZE_W-1:0]   size_ff;
   logic [CW-1:0]       fc_ff [MAX_SLABS];

   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [ADDR_W-1:0]   res_addr_ff, res_addr_in;
   logic                res_created_ff, res_created_in;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [ADDR_W-1:0]   rsp_addr_ff;
   logic                rsp_created_ff;

   logic                fc_wr_en;
   logic [SW-1:0]       fc_wr_idx;
   logic [CW-1:0]       fc_wr_val;

   logic                mem_wr_en;
   logic [AW-1:0]       mem_wr_addr;
   logic [OW-1:0]       mem_wr_data;
   logic                mem_rd_en;
   logic [AW-1:0]       mem_rd_addr;
   logic [OW-1:0]       mem_rd_data;

   logic [CW-1:0]       mac_factor;
   logic [OW-1:0]       mac_offset;
   logic                mac_fits;

   logic                pick_found;
   logic [SW-1:0]       pick_idx;
   logic [ADDR_W:0]     addr_slab_wide;
   logic                addr_in_slab;
   logic [SW-1:0]       addr_slab;
   logic [CW-1:0]       fc_addr_slab;
   logic [CW-1:0]       fc_cur;
   logic [CW-1:0]       fc_pick;
   logic [OW-1:0]       off_sel;
   logic [ADDR_W-1:0]   obj_addr;
   logic                load_rsp;

   assign req_tready = (state_ff == S_IDLE);
   assign load_rsp   = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_tready);

   // newest slab holding a free object wins
   always_comb begin
      pick_found = 1'b0;
      pick_idx   = '0;
      for (int i = 0; i < MAX_SLABS; i++) begin
         if (fc_ff[i] != '0) begin
            pick_found = 1'b1;
            pick_idx   = SW'(i);
         end
      end
   end

   assign addr_slab_wide = {1'b0, addr_ff} >> OW;
   assign addr_in_slab   = addr_slab_wide < (ADDR_W + 1)'(inuse_ff);
   assign addr_slab      = addr_slab_wide[SW-1:0];
   assign fc_addr_slab   = addr_in_slab ? fc_ff[addr_slab] : '0;
   assign fc_cur         = fc_ff[slab_ff];
   assign fc_pick        = fc_ff[pick_idx];

   assign mac_factor = (state_ff == S_FMUL) ? k_ff : fc_addr_slab;

   assign off_sel  = (state_ff == S_POP) ? mem_rd_data : last_off_ff;
   assign obj_addr = ADDR_W'((32'(slab_ff) << OW) | 32'(off_sel));

   always_comb begin
      state_in       = state_ff;
      type_in        = type_ff;
      addr_in        = addr_ff;
      slab_in        = slab_ff;
      k_in           = k_ff;
      last_off_in    = last_off_ff;
      inuse_in       = inuse_ff;
      res_status_in  = res_status_ff;
      res_addr_in    = res_addr_ff;
      res_created_in = res_created_ff;
      fc_wr_en       = 1'b0;
      fc_wr_idx      = slab_ff;
      fc_wr_val      = fc_cur;
      mem_wr_en      = 1'b0;
      mem_wr_addr    = {slab_ff, k_ff[KW-1:0]};
      mem_wr_data    = mac_offset;
      mem_rd_en      = 1'b0;
      mem_rd_addr    = {pick_idx, KW'(fc_pick - CW'(1))};

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               type_in  = req_tuser[0];
               addr_in  = req_tdata;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            res_status_in  = ST_OK;
            res_addr_in    = '0;
            res_created_in = 1'b0;
            if (type_ff == REQ_ALLOC) begin
               if (pick_found) begin
                  slab_in   = pick_idx;
                  fc_wr_en  = 1'b1;
                  fc_wr_idx = pick_idx;
                  fc_wr_val = fc_pick - CW'(1);
                  mem_rd_en = 1'b1;
                  state_in  = S_POP;
               end else if (inuse_ff == UW'(MAX_SLABS)) begin
                  res_status_in = ST_OOM;
                  state_in      = S_RESP;
               end else begin
                  slab_in  = SW'(inuse_ff);
                  k_in     = '0;
                  state_in = S_FMUL;
               end
            end else begin
               if (!addr_in_slab) begin
                  res_status_in = ST_NO_SLAB;
                  state_in      = S_RESP;
               end else begin
                  slab_in  = addr_slab;
                  state_in = S_FCMP;
               end
            end
         end
         S_POP: begin
            res_addr_in = obj_addr;
            state_in    = S_RESP;
         end
         S_FMUL: begin
            state_in = S_FWR;
         end
         S_FWR: begin
            if (k_ff < CW'(MAX_OBJECTS) && mac_fits) begin
               mem_wr_en   = 1'b1;
               last_off_in = mac_offset;
               k_in        = k_ff + CW'(1);
               state_in    = S_FMUL;
            end else begin
               // page holds no object of this size: nothing is created
               if (k_ff == '0) begin
                  res_status_in = ST_OOM;
               end else begin
                  inuse_in       = inuse_ff + UW'(1);
                  fc_wr_en       = 1'b1;
                  fc_wr_val      = k_ff - CW'(1);
                  res_addr_in    = obj_addr;
                  res_created_in = 1'b1;
               end
               state_in = S_RESP;
            end
         end
         S_FCMP: begin
            if (fc_cur >= CW'(MAX_OBJECTS) || !mac_fits) begin
               res_status_in = ST_ALL_FREE;
            end else begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = {slab_ff, fc_cur[KW-1:0]};
               mem_wr_data = addr_ff[OW-1:0];
               fc_wr_en    = 1'b1;
               fc_wr_val   = fc_cur + CW'(1);
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         inuse_ff     <= '0;
         size_ff      <= OBJ_SIZE_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_SLABS; i++) begin
            fc_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         inuse_ff <= inuse_in;
         if (csr_wr_en) begin
            size_ff <= csr_wr_data;
         end
         if (fc_wr_en) begin
            fc_ff[fc_wr_idx] <= fc_wr_val;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      type_ff        <= type_in;
      addr_ff        <= addr_in;
      slab_ff        <= slab_in;
      k_ff           <= k_in;
      last_off_ff    <= last_off_in;
      res_status_ff  <= res_status_in;
      res_addr_ff    <= res_addr_in;
      res_created_ff <= res_created_in;
      if (load_rsp) begin
         rsp_status_ff  <= res_status_ff;
         rsp_addr_ff    <= res_addr_ff;
         rsp_created_ff <= res_created_ff;
      end
   end

   slab_alloc_mac #(
      .FW         (CW),
      .OW         (OW),
      .SLAB_BYTES (SLAB_BYTES)
   ) u_mac (
      .clock    (clock),
      .factor   (mac_factor),
      .obj_size (size_ff),
      .offset   (mac_offset),
      .fits     (mac_fits)
   );

   slab_alloc_store #(
      .AW (AW),
      .DW (OW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_addr_ff;
   assign rsp_tuser  = {rsp_created_ff, rsp_status_ff};

   `SA_ASSERT_ALWAYS(a_inuse_bound, clock, reset, inuse_ff <= UW'(MAX_SLABS))
   `SA_ASSERT_IMPLIES(a_created_ok, clock, reset, rsp_tvalid && rsp_tuser[2],
      rsp_tuser[1:0] == ST_OK)
   `SA_ASSERT_NEXT(a_accept_busy, clock, reset, req_tvalid && req_tready,
      !req_tready && state_ff == S_DECIDE)
   `SA_ASSERT_NEXT(a_create_grows, clock, reset,
      state_ff == S_FWR && state_in == S_RESP && res_created_in,
      inuse_ff == $past(inuse_ff) + UW'(1))

endmodule

### dv/slab_object_allocator_checker.sv
// Reply checker for the slab object allocator: watches the request, reply and
// register ports, predicts each reply and compares it field by field.
// Depends on slab_alloc_pkg.
module slab_object_allocator_checker import slab_alloc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [ADDR_W-1:0]   req_tdata,
   input  logic [0:0]          req_tuser,
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [ADDR_W-1:0]   rsp_tdata,
   input  logic [2:0]          rsp_tuser,
   input  logic                csr_wr_en,
   input  logic [SIZE_W-1:0]   csr_wr_data,
   input  logic                wrap_up,
   output int                  failures
);

   localparam int OFF_W = $clog2(SLAB_BYTES_DEF);

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   obj_addr;
      logic                created;
   } reply_type;

   logic [OFF_W-1:0]  offset_stack [MAX_SLABS_DEF][MAX_OBJECTS_DEF];
   int unsigned       free_objs [MAX_SLABS_DEF];
   int unsigned       slabs_made;
   logic [SIZE_W-1:0] obj_size;
   reply_type         pending_replies [$];
   bit                wrapped;

   function automatic int unsigned slab_capacity();
      int unsigned sz;
      int unsigned n;
      sz = (obj_size == '0) ? 1 : obj_size;
      n  = SLAB_BYTES_DEF / sz;
      return (n > MAX_OBJECTS_DEF) ? MAX_OBJECTS_DEF : n;
   endfunction

   function automatic logic [ADDR_W-1:0] pop_object(int unsigned s);
      free_objs[s]--;
      return ADDR_W'(s * SLAB_BYTES_DEF + offset_stack[s][free_objs[s]]);
   endfunction

   // Advance the allocator state by one request and return its reply
   function automatic reply_type allocator_reply(logic kind, logic [ADDR_W-1:0] addr);
      reply_type   r;
      int unsigned n;
      int unsigned sz;
      int unsigned s;
      bit          found;
      r     = '0;
      n     = slab_capacity();
      found = 1'b0;
      if (kind == REQ_ALLOC) begin
         // newest slab with a free object wins
         for (int i = int'(slabs_made) - 1; i >= 0 && !found; i--) begin
            if (free_objs[i] > 0) begin
               r.obj_addr = pop_object(i);
               found      = 1'b1;
            end
         end
         if (!found) begin
            if (slabs_made >= MAX_SLABS_DEF || n == 0) begin
               r.status = ST_OOM;
            end else begin
               sz = (obj_size == '0) ? 1 : obj_size;
               for (int k = 0; k < n; k++)
                  offset_stack[slabs_made][k] = OFF_W'(k * sz);
               free_objs[slabs_made] = n;
               r.obj_addr = pop_object(slabs_made);
               r.created  = 1'b1;
               slabs_made++;
            end
         end
      end else begin
         s = addr / SLAB_BYTES_DEF;
         if (s >= slabs_made) begin
            r.status = ST_NO_SLAB;
         end else if (free_objs[s] >= n || free_objs[s] >= MAX_OBJECTS_DEF) begin
            r.status = ST_ALL_FREE;
         end else begin
            offset_stack[s][free_objs[s]] = OFF_W'(addr % SLAB_BYTES_DEF);
            free_objs[s]++;
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin : watch
      reply_type got;
      reply_type want;
      if (reset) begin
         foreach (free_objs[i]) free_objs[i] = 0;
         slabs_made = 0;
         obj_size   = OBJ_SIZE_RESET;
         pending_replies.delete();
         failures   = 0;
         wrapped    = 1'b0;
      end else begin
         if (csr_wr_en)
            obj_size = csr_wr_data;
         // compare before queueing, so a reply never meets its own request
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser[1:0], rsp_tdata, rsp_tuser[2]};
            if (pending_replies.size() == 0) begin
               $error("reply with nothing outstanding: status %0d, object_address %h",
                      got.status, got.obj_addr);
               failures++;
            end else begin
               want = pending_replies.pop_front();
               if (got.status != want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, got.status);
                  failures++;
               end
               if (got.obj_addr != want.obj_addr) begin
                  $error("object_address: expected %h, actual %h",
                         want.obj_addr, got.obj_addr);
                  failures++;
               end
               if (got.created != want.created) begin
                  $error("slab_created: expected %0d, actual %0d",
                         want.created, got.created);
                  failures++;
               end
            end
         end
         if (req_tvalid && req_tready)
            pending_replies.push_back(allocator_reply(req_tuser[0], req_tdata));
         if (wrap_up && !wrapped) begin
            if (pending_replies.size() != 0) begin
               $error("%0d replies never arrived", pending_replies.size());
               failures += pending_replies.size();
            end
            wrapped = 1'b1;
         end
      end
   end

endmodule

### dv/testbench.sv
// Top of the slab object allocator bench: clock, reset, request stimulus,
// random reply back-pressure and the verdict.
// Depends on slab_alloc_pkg, slab_object_allocator and its reply checker.
module testbench;
   import slab_alloc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [ADDR_W-1:0]   req_tdata;   // [15:0] free_address
   logic [0:0]          req_tuser;   // [0] req_type
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [ADDR_W-1:0]   rsp_tdata;   // [15:0] object_address
   logic [2:0]          rsp_tuser;   // [1:0] status, [2] slab_created
   logic                csr_wr_en;
   logic [SIZE_W-1:0]   csr_wr_data;
   logic                wrap_up;
   int                  failures;

   int                  idle_pct = 30;
   int unsigned         cycle_count = 0;
   logic                kinds_in_flight [$];
   logic [ADDR_W-1:0]   live_objs [$];
   logic [ADDR_W-1:0]   last_freed = '0;
   logic                done_kind;

   slab_object_allocator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   slab_object_allocator_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .wrap_up     (wrap_up),
      .failures    (failures)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("slab_object_allocator: mismatch");
         $finish;
      end
   end

   // Collect granted objects so that later frees can hand them back
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready && kinds_in_flight.size() != 0) begin
         done_kind = kinds_in_flight.pop_front();
         if (done_kind == REQ_ALLOC && rsp_tuser[1:0] == ST_OK)
            live_objs.push_back(rsp_tdata);
      end
   end

   task automatic issue(logic kind, logic [ADDR_W-1:0] addr);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= addr;
      do @(posedge clock); while (!req_tready);
      kinds_in_flight.push_back(kind);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (kinds_in_flight.size() != 0) @(posedge clock);
   endtask

   task automatic set_obj_size(logic [SIZE_W-1:0] size);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= size;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Mostly allocates and frees of live objects; the rest repeats the last
   // free or frees a random address
   task automatic run_phase(logic [SIZE_W-1:0] size, int items, int alloc_pct);
      int                roll;
      int                idx;
      logic [ADDR_W-1:0] addr;
      set_obj_size(size);
      repeat (items) begin
         roll = $urandom_range(99);
         addr = ADDR_W'($urandom);
         if (roll < alloc_pct) begin
            issue(REQ_ALLOC, addr);
         end else begin
            roll = $urandom_range(99);
            if (roll < 65 && live_objs.size() != 0) begin
               idx  = $urandom_range(live_objs.size() - 1);
               addr = live_objs[idx];
               live_objs.delete(idx);
            end else if (roll < 80) begin
               addr = last_freed;
            end
            last_freed = addr;
            issue(REQ_FREE, addr);
         end
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = REQ_ALLOC;
      csr_wr_en   = 1'b0;
      csr_wr_data = OBJ_SIZE_RESET;
      wrap_up     = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset object size: no slab yet, then create, pop and push unaligned
      issue(REQ_FREE,  16'h0000);
      issue(REQ_ALLOC, 16'hFFFF);
      issue(REQ_ALLOC, 16'h0000);
      issue(REQ_FREE,  16'h0F81);
      issue(REQ_ALLOC, 16'h1234);
      issue(REQ_FREE,  16'h1000);
      issue(REQ_FREE,  16'hFFFF);
      // size zero counts as one byte, so the stack limit is the cap
      set_obj_size('0);
      issue(REQ_FREE,  16'h0F00);
      issue(REQ_ALLOC, 16'h0000);
      // one object per page: the existing stack is already over the limit
      set_obj_size(13'd4096);
      issue(REQ_FREE,  16'h0F80);
      issue(REQ_ALLOC, 16'h5555);
      // larger than a page: no stack can take a free
      set_obj_size('1);
      issue(REQ_FREE,  16'h0F80);
      issue(REQ_ALLOC, 16'hAAAA);

      run_phase(13'd64,   180, 75);
      run_phase('1,       100, 85);   // drain all stacks, then no room for a slab
      run_phase(13'd4096, 100, 85);   // burn the remaining pages one object each
      run_phase('0,       120, 50);
      run_phase(13'd1,    100, 45);
      idle_pct = 0;
      run_phase(13'($urandom_range(4096, 64)), 100, 50);
      idle_pct = 30;
      run_phase(13'd4097, 100, 55);
      run_phase(13'($urandom_range(8191)), 100, 50);
      run_phase(13'd128,  120, 50);
      run_phase(13'($urandom_range(4096, 64)), 100, 50);

      settle();
      repeat (200) @(posedge clock);
      wrap_up <= 1'b1;
      repeat (2) @(posedge clock);
      if (failures == 0) begin
         $display("slab_object_allocator: match");
      end else begin
         $display("slab_object_allocator: mismatch");
      end
      $finish;
   end

endmodule
